### hdl/cc20_pkg.sv
`timescale 1ns / 1ps

package cc20_pkg;

  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  localparam int BLOCK_WORDS   = 16;
  localparam int DOUBLE_ROUNDS = 10;
  // four add/xor/rotate steps per quarter round, eight quarter rounds per double round
  localparam int ROUND_STEPS   = DOUBLE_ROUNDS * 8 * 4;
  localparam int STEP_W        = $clog2(ROUND_STEPS);
  localparam int WORD_IDX_W    = $clog2(BLOCK_WORDS);
  localparam int CFG_IDX_W     = 3;

  localparam logic [5:0] LAST_OFFSET = 6'd63;

  typedef logic [31:0] word_t;
  typedef logic [BLOCK_WORDS-1:0][31:0] state_block_t;

  typedef enum logic [1:0] {
    ROT16,
    ROT12,
    ROT8,
    ROT7
  } rot_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ROUND,
    CS_ADD
  } core_state_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_GEN,
    ST_RUN
  } top_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0,
    REG_KEY1,
    REG_KEY2,
    REG_KEY3,
    REG_NONCE_LO,
    REG_NONCE_HI,
    REG_START
  } cfg_reg_t;

  // keystream buffer write from the round core
  typedef struct packed {
    logic                  we;
    logic [WORD_IDX_W-1:0] idx;
    word_t                 word;
    logic                  done;
  } ks_wr_t;

endpackage

### hdl/cc20_ifs.sv
`timescale 1ns / 1ps

interface cc20_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cc20_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

interface cc20_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cc20_pkg::CFG_IDX_W-1:0] index;
  logic [63:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/chacha20_stream_xor_unit.sv
`timescale 1ns / 1ps

// ChaCha20 byte stream XOR.
// msg (sink): one word per byte, data_byte plus last_byte marking message end.
// cipher (source): out_byte = data_byte ^ keystream byte, out_last copied.
// cfg (sink): always ready; index 0..3 key, 4..5 nonce, 6 start counter.
//   Key or nonce writes force a keystream recompute at the current position;
//   a start counter write restarts the message at byte 0. Index 7 is ignored.
// A result is registered in the output register in the cycle after its byte
// is taken. Within a keystream block one byte is taken per cycle, also while
// a result waits, as long as the output register is free or being drained.
// Keystream refill, with msg.ready low: one load, 320 add/xor/rotate
// steps of the single ARX unit and 16 final adds; it runs after reset, after every
// 64th byte, after a last byte and after any key, nonce or start counter write.
// Reset clears the config registers, the counter and the byte offset, and
// starts a refill. A stalled receiver holds the result and blocks the input.
module chacha20_stream_xor_unit (
  input  logic     clk,
  input  logic     rst,
  cc20_msg_if.sink   msg,
  cc20_res_if.source cipher,
  cc20_cfg_if.sink   cfg
);
  import cc20_pkg::*;

  top_state_t   state, state_next;
  logic [63:0]  key0, key1, key2, key3, nonce_lo;
  logic [31:0]  nonce_hi, start_ctr, block_count;
  logic [5:0]   offset;
  state_block_t ks_buf;
  state_block_t init;
  ks_wr_t       ks_wr;
  logic         core_start;
  logic         cfg_we, cfg_hit, msg_acc;
  word_t        ks_word;
  logic [7:0]   ks_byte;
  logic         out_valid, out_last;
  logic [7:0]   out_byte;

  assign init = {nonce_hi, nonce_lo[63:32], nonce_lo[31:0], block_count,
                 key3[63:32], key3[31:0], key2[63:32], key2[31:0],
                 key1[63:32], key1[31:0], key0[63:32], key0[31:0],
                 SIGMA3, SIGMA2, SIGMA1, SIGMA0};

  cc20_core u_core (
    .clk   (clk),
    .rst   (rst),
    .start (core_start),
    .init  (init),
    .ks_wr (ks_wr)
  );

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid && cfg.ready;

  always_comb begin
    case (cfg.index)
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3,
      REG_NONCE_LO, REG_NONCE_HI, REG_START: cfg_hit = cfg_we;
      default: cfg_hit = 1'b0;
    endcase
  end

  assign msg_acc = msg.valid && msg.ready;
  assign ks_word = ks_buf[offset[5:2]];
  assign ks_byte = ks_word[{offset[1:0], 3'b000} +: 8];

  always_comb begin : fsm_next
    state_next = state;
    if (cfg_hit) begin
      state_next = ST_LOAD;
    end else begin
      case (state)
        ST_LOAD: state_next = ST_GEN;
        ST_GEN:  if (ks_wr.done) state_next = ST_RUN;
        ST_RUN:  if (msg_acc && (msg.last_byte || offset == LAST_OFFSET)) state_next = ST_LOAD;
        default: state_next = ST_LOAD;
      endcase
    end
  end

  always_comb begin : fsm_out
    core_start = (state == ST_LOAD);
    msg.ready  = (state == ST_RUN) && (!out_valid || cipher.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key0      <= '0;
      key1      <= '0;
      key2      <= '0;
      key3      <= '0;
      nonce_lo  <= '0;
      nonce_hi  <= '0;
      start_ctr <= '0;
    end else if (cfg_we) begin
      case (cfg.index)
        REG_KEY0:     key0      <= cfg.data;
        REG_KEY1:     key1      <= cfg.data;
        REG_KEY2:     key2      <= cfg.data;
        REG_KEY3:     key3      <= cfg.data;
        REG_NONCE_LO: nonce_lo  <= cfg.data;
        REG_NONCE_HI: nonce_hi  <= cfg.data[31:0];
        REG_START:    start_ctr <= cfg.data[31:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= '0;
      offset      <= '0;
    end else if (cfg_we && cfg.index == REG_START) begin
      block_count <= cfg.data[31:0];
      offset      <= '0;
    end else if (msg_acc) begin
      if (msg.last_byte) begin
        block_count <= start_ctr;
        offset      <= '0;
      end else if (offset == LAST_OFFSET) begin
        block_count <= block_count + 32'd1;
        offset      <= '0;
      end else begin
        offset <= offset + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ks_wr.we) begin
      ks_buf[ks_wr.idx] <= ks_wr.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (msg_acc) begin
      out_valid <= 1'b1;
    end else if (cipher.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_acc) begin
      out_byte <= msg.data_byte ^ ks_byte;
      out_last <= msg.last_byte;
    end
  end

  assign cipher.valid    = out_valid;
  assign cipher.out_byte = out_byte;
  assign cipher.out_last = out_last;

endmodule

### hdl/cc20_arx.sv
`timescale 1ns / 1ps

module cc20_arx (
  input  cc20_pkg::word_t x,
  input  cc20_pkg::word_t y,
  input  cc20_pkg::word_t z,
  input  cc20_pkg::rot_t  rot,
  output cc20_pkg::word_t sum,
  output cc20_pkg::word_t mix
);
  import cc20_pkg::*;

  word_t t;

  assign sum = x + y;
  assign t   = z ^ sum;

  always_comb begin
    case (rot)
      ROT16:   mix = {t[15:0], t[31:16]};
      ROT12:   mix = {t[19:0], t[31:20]};
      ROT8:    mix = {t[23:0], t[31:24]};
      ROT7:    mix = {t[24:0], t[31:25]};
      default: mix = t;
    endcase
  end

endmodule

### hdl/cc20_core.sv
`timescale 1ns / 1ps

// State is kept as four rows of four words. Every quarter round works on
// column 0 (words 0, 4, 8, 12); rows rotate one word after each quarter
// round, and at the end of a half round they get an extra row-dependent
// rotation that lines up (or undoes) the diagonals.
module cc20_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  cc20_pkg::state_block_t init,
  output cc20_pkg::ks_wr_t       ks_wr
);
  import cc20_pkg::*;

  localparam logic [STEP_W-1:0]     STEP_LAST = STEP_W'(ROUND_STEPS - 1);
  localparam logic [WORD_IDX_W-1:0] WORD_LAST = WORD_IDX_W'(BLOCK_WORDS - 1);

  core_state_t           state, state_next;
  logic [STEP_W-1:0]     step;
  logic [WORD_IDX_W-1:0] k;
  state_block_t          w, w_next;

  word_t op_x, op_y, op_z, sum, mix;
  rot_t  rot;

  cc20_arx u_arx (
    .x   (op_x),
    .y   (op_y),
    .z   (op_z),
    .rot (rot),
    .sum (sum),
    .mix (mix)
  );

  always_comb begin : fsm_next
    state_next = state;
    if (start) begin
      state_next = CS_ROUND;
    end else begin
      case (state)
        CS_ROUND: if (step == STEP_LAST) state_next = CS_ADD;
        CS_ADD:   if (k == WORD_LAST) state_next = CS_IDLE;
        default:  state_next = state;
      endcase
    end
  end

  always_comb begin : fsm_out
    ks_wr.we   = (state == CS_ADD);
    ks_wr.idx  = k;
    ks_wr.word = sum;
    ks_wr.done = (state == CS_ADD) && (k == WORD_LAST);
    case (state)
      CS_ADD: begin
        op_x = w[0];
        op_y = init[k];
        op_z = w[0];
        rot  = ROT16;
      end
      default: begin
        if (!step[0]) begin
          op_x = w[0];
          op_y = w[4];
          op_z = w[12];
        end else begin
          op_x = w[8];
          op_y = w[12];
          op_z = w[4];
        end
        case (step[1:0])
          2'd0:    rot = ROT16;
          2'd1:    rot = ROT12;
          2'd2:    rot = ROT8;
          default: rot = ROT7;
        endcase
      end
    endcase
  end

  always_comb begin : datapath
    state_block_t u;
    state_block_t rowed;
    logic [1:0]   n;
    u = w;
    if (!step[0]) begin
      u[0]  = sum;
      u[12] = mix;
    end else begin
      u[8] = sum;
      u[4] = mix;
    end
    rowed = u;
    for (int r = 0; r < 4; r++) begin
      n = 2'd1;
      if (step[3:2] == 2'd3) begin
        // column half ends: shift row r by r more; diagonal half ends: undo it
        n = step[4] ? 2'(1 - r) : 2'(1 + r);
      end
      for (int j = 0; j < 4; j++) begin
        rowed[{2'(r), 2'(j)}] = u[{2'(r), 2'(2'(j) + n)}];
      end
    end
    case (state)
      CS_ROUND: w_next = (step[1:0] == 2'd3) ? rowed : u;
      CS_ADD:   w_next = {w[BLOCK_WORDS-1], w[BLOCK_WORDS-1:1]};
      default:  w_next = w;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
      step  <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        step <= '0;
        k    <= '0;
      end else if (state == CS_ROUND) begin
        step <= step + STEP_W'(1);
      end else if (state == CS_ADD) begin
        k <= k + WORD_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w <= init;
    end else begin
      w <= w_next;
    end
  end

endmodule

### hdl/cc20_checker.sv
`timescale 1ns / 1ps

module cc20_checker (
  input logic       clk,
  input logic       rst,
  input logic       msg_valid,
  input logic       msg_ready,
  input logic       msg_last,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_byte,
  input logic       res_last
);

  logic msg_acc;
  assign msg_acc = msg_valid && msg_ready;

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result word present right after reset");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    msg_acc |=> res_valid)
    else $error("accepted byte gave no result word");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !msg_ready)
    else $error("byte taken while result stalled");

  a_refill_after_last: assert property (@(posedge clk) disable iff (rst)
    (msg_acc && msg_last) |=> !msg_ready)
    else $error("byte taken before keystream refill after last");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_byte) && $stable(res_last)))
    else $error("stalled result word changed");

endmodule

bind chacha20_stream_xor_unit cc20_checker u_cc20_checker (
  .clk       (clk),
  .rst       (rst),
  .msg_valid (msg.valid),
  .msg_ready (msg.ready),
  .msg_last  (msg.last_byte),
  .res_valid (cipher.valid),
  .res_ready (cipher.ready),
  .res_byte  (cipher.out_byte),
  .res_last  (cipher.out_last)
);

### tb/chacha20_xor_check.sv
`timescale 1ns / 1ps

module chacha20_xor_check (
  input  logic clk,
  input  logic rst,
  cc20_msg_if  msg,
  cc20_res_if  cipher,
  cc20_cfg_if  cfg,
  output int   fails,
  output int   pending
);
  import cc20_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_word_t;

  logic [63:0]       key_q [4];
  logic [63:0]       nonce_lo_q;
  logic [31:0]       nonce_hi_q;
  logic [31:0]       start_q;
  logic [31:0]       blk_ctr;
  logic [5:0]        offset;
  logic [15:0][31:0] ks_block;
  logic              ks_ok;
  cipher_word_t      expected_cipher [$];

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // keystream block for counter ctr under the current key and nonce
  function automatic logic [15:0][31:0] chacha_block(input logic [31:0] ctr);
    logic [31:0]       init [BLOCK_WORDS];
    logic [31:0]       w [BLOCK_WORDS];
    logic [15:0][31:0] blk;
    int                q, a, b, c, d;
    init[0] = SIGMA0;
    init[1] = SIGMA1;
    init[2] = SIGMA2;
    init[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2 * i] = key_q[i][31:0];
      init[5 + 2 * i] = key_q[i][63:32];
    end
    init[12] = ctr;
    init[13] = nonce_lo_q[31:0];
    init[14] = nonce_lo_q[63:32];
    init[15] = nonce_hi_q;
    w = init;
    for (int r = 0; r < DOUBLE_ROUNDS * 8; r++) begin
      q = r % 8;
      // first four: columns, last four: diagonals
      if (q < 4) begin
        a = q;
        b = q + 4;
        c = q + 8;
        d = q + 12;
      end else begin
        a = q - 4;
        b = 4 + (q - 3) % 4;
        c = 8 + (q - 2) % 4;
        d = 12 + (q - 1) % 4;
      end
      w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 16);
      w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 12);
      w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 8);
      w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 7);
    end
    for (int i = 0; i < BLOCK_WORDS; i++) begin
      blk[i] = w[i] + init[i];
    end
    return blk;
  endfunction

  always @(posedge clk) begin
    cipher_word_t want;
    logic [7:0]   kb;
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        key_q[i] = '0;
      end
      nonce_lo_q = '0;
      nonce_hi_q = '0;
      start_q    = '0;
      blk_ctr    = '0;
      offset     = '0;
      ks_ok      = 1'b0;
      expected_cipher.delete();
      fails      = 0;
    end else begin
      if (cipher.valid && cipher.ready) begin
        if (expected_cipher.size() == 0) begin
          $error("out_byte: expected none, got %h (out_last %b)",
                 cipher.out_byte, cipher.out_last);
          fails++;
        end else begin
          want = expected_cipher.pop_front();
          if (cipher.out_byte !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, cipher.out_byte);
            fails++;
          end
          if (cipher.out_last !== want.last) begin
            $error("out_last: expected %b, got %b", want.last, cipher.out_last);
            fails++;
          end
        end
      end

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_KEY0: begin key_q[0] = cfg.data; ks_ok = 1'b0; end
          REG_KEY1: begin key_q[1] = cfg.data; ks_ok = 1'b0; end
          REG_KEY2: begin key_q[2] = cfg.data; ks_ok = 1'b0; end
          REG_KEY3: begin key_q[3] = cfg.data; ks_ok = 1'b0; end
          REG_NONCE_LO: begin nonce_lo_q = cfg.data; ks_ok = 1'b0; end
          REG_NONCE_HI: begin nonce_hi_q = cfg.data[31:0]; ks_ok = 1'b0; end
          REG_START: begin
            start_q = cfg.data[31:0];
            blk_ctr = start_q;
            offset  = '0;
            ks_ok   = 1'b0;
          end
          default: ;
        endcase
      end

      if (msg.valid && msg.ready) begin
        if (!ks_ok) begin
          ks_block = chacha_block(blk_ctr);
          ks_ok    = 1'b1;
        end
        kb = ks_block[offset[5:2]][{offset[1:0], 3'b000} +: 8];
        want.data = msg.data_byte ^ kb;
        want.last = msg.last_byte;
        expected_cipher = {expected_cipher, want};
        if (msg.last_byte) begin
          blk_ctr = start_q;
          offset  = '0;
          ks_ok   = 1'b0;
        end else if (offset == LAST_OFFSET) begin
          offset  = '0;
          blk_ctr = blk_ctr + 32'd1;
          ks_ok   = 1'b0;
        end else begin
          offset = offset + 6'd1;
        end
      end
    end
    pending = expected_cipher.size();
  end

endmodule

### tb/tb_chacha20_stream_xor_unit.sv
`timescale 1ns / 1ps

module tb_chacha20_stream_xor_unit;
  import cc20_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
  localparam int                   HOLD_CYCLES = 300;
  localparam int                   PHASE_WORDS = 160;

  logic clk = 1'b0;
  logic rst;
  int   snd_idle;
  int   rcv_stall;
  int   hold_asks;
  int   fails;
  int   pending;
  int   sent;

  cc20_msg_if msg_ch ();
  cc20_res_if cipher_ch ();
  cc20_cfg_if cfg_ch ();

  chacha20_stream_xor_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .cipher (cipher_ch),
    .cfg    (cfg_ch)
  );

  chacha20_xor_check cipher_chk (
    .clk     (clk),
    .rst     (rst),
    .msg     (msg_ch),
    .cipher  (cipher_ch),
    .cfg     (cfg_ch),
    .fails   (fails),
    .pending (pending)
  );

  always #2 clk = ~clk;

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    cipher_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        cipher_ch.ready <= 1'b0;
      end else begin
        cipher_ch.ready <= ($urandom_range(99) >= rcv_stall);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic l);
    msg_ch.valid     <= 1'b1;
    msg_ch.data_byte <= d;
    msg_ch.last_byte <= l;
    do @(posedge clk); while (!msg_ch.ready);
    sent++;
    if ($urandom_range(99) < snd_idle) begin
      msg_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
  endtask

  task automatic send_message(input int len, input logic ends);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), ends && (i == len - 1));
    end
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    msg_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3,
                           input logic [63:0] nlo, input logic [63:0] nhi,
                           input logic [63:0] st);
    write_reg(REG_KEY0, k0);
    write_reg(REG_KEY1, k1);
    write_reg(REG_KEY2, k2);
    write_reg(REG_KEY3, k3);
    write_reg(REG_NONCE_LO, nlo);
    write_reg(REG_NONCE_HI, nhi);
    write_reg(REG_START, st);
  endtask

  // mostly whole messages; now and then one broken off by a register write
  task automatic run_phase(input int budget);
    int first;
    int len;
    int kind;
    first = sent;
    while (sent - first < budget) begin
      kind = $urandom_range(9);
      if (kind == 0) len = 1;
      else if (kind == 1) len = 64 * $urandom_range(1, 2) + $urandom_range(1) - 1;
      else len = $urandom_range(2, 140);
      if (kind == 2) begin
        send_message(len, 1'b0);
        drain();
        write_reg(CFG_IDX_W'($urandom_range(7)), rnd64());
      end else begin
        send_message(len, 1'b1);
      end
    end
    drain();
  endtask

  initial begin
    rst              <= 1'b1;
    msg_ch.valid     <= 1'b0;
    msg_ch.data_byte <= '0;
    msg_ch.last_byte <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_KEY0;
    cfg_ch.data      <= '0;
    hold_asks        <= 0;
    snd_idle  = 0;
    rcv_stall = 0;
    sent      = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset key and nonce, byte extremes, a single-byte message
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'ha5, 1'b1);
    send_byte(8'h5a, 1'b1);
    drain();
    load_regs(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
              64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
              64'h4a00000009000000, 64'h0, 64'h1);
    send_message(4, 1'b0);
    drain();
    // key and nonce change mid-message: same position, new keystream
    write_reg(REG_KEY2, rnd64());
    write_reg(REG_NONCE_HI, rnd64());
    send_message(3, 1'b0);
    drain();
    write_reg(REG_UNUSED, '1);
    send_message(2, 1'b0);
    drain();
    write_reg(REG_START, '1);
    send_message(3, 1'b1);
    send_byte(8'hff, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          snd_idle  = 0;
          rcv_stall = 0;
          load_regs(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
        end
        1: begin
          snd_idle  = 77;
          rcv_stall = 0;
          load_regs('1, '1, '1, '1, '1, '1, '1);
        end
        2: begin
          snd_idle  = 0;
          rcv_stall = 77;
          load_regs('0, '0, '0, '0, '0, '0, '0);
        end
        default: begin
          snd_idle  = 23;
          rcv_stall = 23;
          load_regs(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(),
                    64'hffff_fffe);
        end
      endcase
      run_phase(PHASE_WORDS);
    end

    // long receiver hold-off while bytes keep coming
    snd_idle  = 0;
    rcv_stall = 0;
    hold_asks <= hold_asks + 1;
    send_message(90, 1'b1);
    drain();
    send_message(20, 1'b1);
    drain();

    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
